[rtl/fbpb_pkg.sv]
// ----------------------------------------------------------------------------
// fbpb_pkg
// Shared types and constants of the projection-back beamformer.
// ----------------------------------------------------------------------------
package fbpb_pkg;

  // Operation codes of an input item.
  localparam logic OpWeight = 1'b0;
  localparam logic OpSample = 1'b1;

  // Configuration register indexes.
  localparam logic [1:0] RegForget  = 2'd0;
  localparam logic [1:0] RegRefChan = 2'd1;
  localparam logic [1:0] RegLowBin  = 2'd2;
  localparam logic [1:0] RegHighBin = 2'd3;

  // Configuration reset values.
  localparam logic [15:0] ForgetReset = 16'd58982;
  localparam logic [2:0]  RefReset    = 3'd0;
  localparam logic [7:0]  LowReset    = 8'd1;
  localparam logic [8:0]  HighReset   = 9'd128;

  // Shared multiplier operand and accumulator widths.
  localparam int MulAW = 26;
  localparam int MulBW = 37;
  localparam int AccW  = 64;

  // Projection-back word: numerator real, numerator imaginary, denominator.
  localparam int PbW = 96;
  localparam logic [PbW-1:0] PbInit = {32'd65536, 32'd0, 32'd65536};

  // Weight word: real over imaginary.
  localparam int WtW = 32;

  typedef enum logic [1:0] {
    MAC_NOP,
    MAC_LOAD,
    MAC_ADD,
    MAC_SUB
  } mac_op_e;

  typedef enum logic [5:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_W1, ST_W2, ST_W3, ST_W4, ST_W5, ST_W6,
    ST_Y,
    ST_M1, ST_M2, ST_M3, ST_M4, ST_M5, ST_M6, ST_M7, ST_M8, ST_M9, ST_M10,
    ST_M11, ST_M12, ST_M13, ST_M14, ST_M15, ST_M16, ST_M17, ST_M18, ST_M19,
    ST_M20,
    ST_DIV_RE,
    ST_DIV_IM,
    ST_EMIT
  } state_e;

endpackage

[rtl/fixed_beamformer_projection_back.sv]
// ----------------------------------------------------------------------------
// fixed_beamformer_projection_back
// Filter-and-sum beamformer per frequency bin with projection-back scaling.
// ----------------------------------------------------------------------------
// Input items either load a complex weight for one bin and channel, or
// deliver one channel sample. Samples accumulate conj(weight)*sample; the
// sample item marked last_channel yields one result item on the output
// channel. Weight loads are taken while idle; each sample item runs the
// weight steps, and the last of an in-band bin also the shared multiplier
// sequence (20 steps) and two 16-step serial divisions. The smoothed
// numerator and denominator of each bin live in one memory, read for each
// sample, written back once per in-band bin; weights live in a second one.
// After reset the block sweeps the projection-back memory to its initial
// values at every address, with in_ready_o low; configuration writes are
// taken throughout. A finished result waits in an output register, so a new
// item is accepted while the receiver stalls; a further result then waits
// until the register is free. Configuration is an APB-style port with
// registers at byte addresses 0, 4, 8 and 12.
// ----------------------------------------------------------------------------
module fixed_beamformer_projection_back
  import fbpb_pkg::*;
#(
  parameter int NUM_BINS     = 256,
  parameter int NUM_CHANNELS = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // Configuration port.
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  // Input channel.
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               operation_i,
  input  logic [7:0]         bin_index_i,
  input  logic [2:0]         channel_index_i,
  input  logic signed [15:0] sample_real_i,
  input  logic signed [15:0] sample_imag_i,
  input  logic signed [15:0] weight_real_i,
  input  logic signed [15:0] weight_imag_i,
  input  logic               last_channel_i,
  // Output channel.
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [7:0]         out_bin_o,
  output logic signed [15:0] out_real_o,
  output logic signed [15:0] out_imag_o,
  output logic               saturated_o
);

  localparam int WAW = $clog2(NUM_BINS * NUM_CHANNELS);
  localparam int PAW = $clog2(NUM_BINS);

  // Configuration registers.
  logic [15:0] forget_q;
  logic [2:0]  ref_chan_q;
  logic [7:0]  low_bin_q;
  logic [8:0]  high_bin_q;

  // Control.
  state_e         state_q, state_d;
  logic [PAW-1:0] clr_cnt_q;
  logic           in_fire;
  logic           ch_ok;
  logic           bin_ok;
  logic           emit_go;

  // Item registers.
  logic              last_q;
  logic              w_ok_q;
  logic              ch_ok_q;
  logic              in_band_q;
  logic [7:0]        bin_q;
  logic [2:0]        ch_q;
  logic signed [15:0] x_re_q, x_im_q;

  // Accumulators and reference.
  logic signed [39:0] sum_re_q, sum_im_q;
  logic signed [15:0] ref_re_q, ref_im_q;

  // Projection-back datapath.
  logic signed [25:0] yr_q, yi_q;
  logic signed [27:0] pr_q, pi_q;
  logic [35:0]        pd_q;
  logic signed [31:0] nr_q, ni_q;
  logic [31:0]        den_q;
  logic signed [63:0] prod_re_q, prod_im_q;

  // Result registers.
  logic signed [15:0] res_re_q, res_im_q;
  logic               res_sat_q;

  // Output register.
  logic               out_valid_q;
  logic [7:0]         out_bin_q;
  logic signed [15:0] out_re_q, out_im_q;
  logic               out_sat_q;

  // Memory ports.
  logic           wt_we, wt_re;
  logic [WAW-1:0] wt_addr;
  logic [WtW-1:0] wt_rdata;
  logic           pb_we, pb_re;
  logic [PAW-1:0] pb_waddr, pb_raddr;
  logic [PbW-1:0] pb_wdata, pb_rdata;

  // Multiplier and divider.
  logic signed [MulAW-1:0] mul_a;
  logic signed [MulBW-1:0] mul_b;
  mac_op_e                 mul_op;
  logic signed [AccW-1:0]  acc;
  logic signed [AccW-1:0]  rnd14, rnd16;
  logic                    div_start, div_done, div_clip;
  logic [15:0]             div_quot;
  logic signed [63:0]      div_num;

  // Operand views.
  logic signed [15:0] w_re, w_im;
  logic signed [31:0] pb_nr, pb_ni;
  logic [31:0]        pb_den;
  logic [16:0]        gf;
  logic signed [31:0] nr_sat;
  logic [31:0]        den_sat;

  // Saturate a signed value to 32 bits.
  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -64'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // Configuration port.
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      forget_q   <= ForgetReset;
      ref_chan_q <= RefReset;
      low_bin_q  <= LowReset;
      high_bin_q <= HighReset;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3:2])
        RegForget:  forget_q   <= pwdata[15:0];
        RegRefChan: ref_chan_q <= pwdata[2:0];
        RegLowBin:  low_bin_q  <= pwdata[7:0];
        RegHighBin: high_bin_q <= pwdata[8:0];
        default:    forget_q   <= forget_q;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      RegForget:  prdata = {16'd0, forget_q};
      RegRefChan: prdata = {29'd0, ref_chan_q};
      RegLowBin:  prdata = {24'd0, low_bin_q};
      RegHighBin: prdata = {23'd0, high_bin_q};
      default:    prdata = '0;
    endcase
  end

  // Input decode.
  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign ch_ok      = int'(channel_index_i) < NUM_CHANNELS;
  assign bin_ok     = int'(bin_index_i) < NUM_BINS;
  assign wt_addr    = WAW'(int'(bin_index_i) * NUM_CHANNELS + int'(channel_index_i));
  assign wt_we      = in_fire && (operation_i == OpWeight) && ch_ok && bin_ok;
  assign wt_re      = in_fire && (operation_i == OpSample);

  // Weight memory.
  fbpb_ram #(
    .WIDTH (WtW),
    .DEPTH (NUM_BINS * NUM_CHANNELS)
  ) u_wt_ram (
    .clk_i   (clk_i),
    .we_i    (wt_we),
    .waddr_i (wt_addr),
    .wdata_i ({weight_real_i, weight_imag_i}),
    .re_i    (wt_re),
    .raddr_i (wt_addr),
    .rdata_o (wt_rdata)
  );

  // Projection-back memory: cleared after reset, updated once per in-band bin.
  assign pb_we    = (state_q == ST_CLEAR) || (state_q == ST_M15);
  assign pb_waddr = (state_q == ST_CLEAR) ? clr_cnt_q : PAW'(int'(bin_q));
  assign pb_wdata = (state_q == ST_CLEAR) ? PbInit : {nr_q, ni_q, den_q};
  assign pb_re    = (state_q == ST_W6);
  assign pb_raddr = PAW'(int'(bin_q));

  fbpb_ram #(
    .WIDTH (PbW),
    .DEPTH (NUM_BINS)
  ) u_pb_ram (
    .clk_i   (clk_i),
    .we_i    (pb_we),
    .waddr_i (pb_waddr),
    .wdata_i (pb_wdata),
    .re_i    (pb_re),
    .raddr_i (pb_raddr),
    .rdata_o (pb_rdata)
  );

  // Operand views.
  assign w_re    = w_ok_q ? $signed(wt_rdata[31:16]) : 16'sd0;
  assign w_im    = w_ok_q ? $signed(wt_rdata[15:0]) : 16'sd0;
  assign pb_nr   = $signed(pb_rdata[95:64]);
  assign pb_ni   = $signed(pb_rdata[63:32]);
  assign pb_den  = pb_rdata[31:0];
  assign gf      = 17'h10000 - {1'b0, forget_q};
  assign rnd14   = (acc + 64'sd8192) >>> 14;
  assign rnd16   = (acc + 64'sd32768) >>> 16;
  assign nr_sat  = sat32(rnd16);
  assign den_sat = (rnd16 > 64'sd4294967295) ? 32'hffffffff : rnd16[31:0];

  // Multiplier operand selection per sequencer step.
  always_comb begin
    mul_a  = '0;
    mul_b  = '0;
    mul_op = MAC_NOP;
    case (state_q)
      ST_W1:  begin mul_a = MulAW'(w_re); mul_b = MulBW'(x_re_q); mul_op = MAC_LOAD; end
      ST_W2:  begin mul_a = MulAW'(w_im); mul_b = MulBW'(x_im_q); mul_op = MAC_ADD;  end
      ST_W3:  begin mul_a = MulAW'(w_re); mul_b = MulBW'(x_im_q); mul_op = MAC_LOAD; end
      ST_W4:  begin mul_a = MulAW'(w_im); mul_b = MulBW'(x_re_q); mul_op = MAC_SUB;  end
      ST_M1:  begin mul_a = yr_q; mul_b = MulBW'(ref_re_q); mul_op = MAC_LOAD; end
      ST_M2:  begin mul_a = yi_q; mul_b = MulBW'(ref_im_q); mul_op = MAC_ADD;  end
      ST_M3:  begin mul_a = yr_q; mul_b = MulBW'(ref_im_q); mul_op = MAC_LOAD; end
      ST_M4:  begin mul_a = yi_q; mul_b = MulBW'(ref_re_q); mul_op = MAC_SUB;  end
      ST_M5:  begin mul_a = yr_q; mul_b = MulBW'(yr_q); mul_op = MAC_LOAD; end
      ST_M6:  begin mul_a = yi_q; mul_b = MulBW'(yi_q); mul_op = MAC_ADD;  end
      ST_M7:  begin
        mul_a = MulAW'({1'b0, forget_q}); mul_b = MulBW'(pb_nr); mul_op = MAC_LOAD;
      end
      ST_M8:  begin mul_a = MulAW'(gf); mul_b = MulBW'(pr_q); mul_op = MAC_ADD; end
      ST_M9:  begin
        mul_a = MulAW'({1'b0, forget_q}); mul_b = MulBW'(pb_ni); mul_op = MAC_LOAD;
      end
      ST_M10: begin mul_a = MulAW'(gf); mul_b = MulBW'(pi_q); mul_op = MAC_ADD; end
      ST_M11: begin
        mul_a = MulAW'({1'b0, forget_q}); mul_b = MulBW'({1'b0, pb_den});
        mul_op = MAC_LOAD;
      end
      ST_M12: begin mul_a = MulAW'(gf); mul_b = MulBW'({1'b0, pd_q}); mul_op = MAC_ADD; end
      ST_M15: begin mul_a = yr_q; mul_b = MulBW'(nr_q); mul_op = MAC_LOAD; end
      ST_M16: begin mul_a = yi_q; mul_b = MulBW'(ni_q); mul_op = MAC_SUB;  end
      ST_M17: begin mul_a = yr_q; mul_b = MulBW'(ni_q); mul_op = MAC_LOAD; end
      ST_M18: begin mul_a = yi_q; mul_b = MulBW'(nr_q); mul_op = MAC_ADD;  end
      default: mul_op = MAC_NOP;
    endcase
  end

  fbpb_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .op_i   (mul_op),
    .acc_o  (acc)
  );

  // Divider: real part first, then imaginary.
  assign div_start = (state_q == ST_M20) || ((state_q == ST_DIV_RE) && div_done);
  assign div_num   = (state_q == ST_M20) ? prod_re_q : prod_im_q;

  fbpb_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (den_q),
    .done_o  (div_done),
    .quot_o  (div_quot),
    .clip_o  (div_clip)
  );

  // Next state.
  assign emit_go = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (clr_cnt_q == PAW'(NUM_BINS - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_fire && (operation_i == OpSample)) begin
          state_d = ST_W1;
        end
      end
      ST_W1:  state_d = ST_W2;
      ST_W2:  state_d = ST_W3;
      ST_W3:  state_d = ST_W4;
      ST_W4:  state_d = ST_W5;
      ST_W5:  state_d = ST_W6;
      ST_W6: begin
        if (!last_q) begin
          state_d = ST_IDLE;
        end else if (in_band_q) begin
          state_d = ST_Y;
        end else begin
          state_d = ST_EMIT;
        end
      end
      ST_Y:   state_d = ST_M1;
      ST_M1:  state_d = ST_M2;
      ST_M2:  state_d = ST_M3;
      ST_M3:  state_d = ST_M4;
      ST_M4:  state_d = ST_M5;
      ST_M5:  state_d = ST_M6;
      ST_M6:  state_d = ST_M7;
      ST_M7:  state_d = ST_M8;
      ST_M8:  state_d = ST_M9;
      ST_M9:  state_d = ST_M10;
      ST_M10: state_d = ST_M11;
      ST_M11: state_d = ST_M12;
      ST_M12: state_d = ST_M13;
      ST_M13: state_d = ST_M14;
      ST_M14: state_d = ST_M15;
      ST_M15: state_d = (den_q == 32'd0) ? ST_EMIT : ST_M16;
      ST_M16: state_d = ST_M17;
      ST_M17: state_d = ST_M18;
      ST_M18: state_d = ST_M19;
      ST_M19: state_d = ST_M20;
      ST_M20: state_d = ST_DIV_RE;
      ST_DIV_RE: begin
        if (div_done) begin
          state_d = ST_DIV_IM;
        end
      end
      ST_DIV_IM: begin
        if (div_done) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (emit_go) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // State, clearing counter, accumulators and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_cnt_q   <= '0;
      sum_re_q    <= '0;
      sum_im_q    <= '0;
      ref_re_q    <= '0;
      ref_im_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) begin
        clr_cnt_q <= clr_cnt_q + PAW'(1);
      end
      if (state_q == ST_W1 && ch_ok_q && ch_q == ref_chan_q) begin
        ref_re_q <= x_re_q;
        ref_im_q <= x_im_q;
      end
      if (state_q == ST_W4) begin
        sum_re_q <= sum_re_q + acc[39:0];
      end
      if (state_q == ST_W6) begin
        sum_im_q <= sum_im_q + acc[39:0];
      end
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (state_q == ST_EMIT && emit_go) begin
        out_valid_q <= 1'b1;
        sum_re_q    <= '0;
        sum_im_q    <= '0;
        ref_re_q    <= '0;
        ref_im_q    <= '0;
      end
    end
  end

  // Item capture and datapath registers.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      last_q    <= last_channel_i;
      w_ok_q    <= ch_ok && bin_ok;
      ch_ok_q   <= ch_ok;
      in_band_q <= bin_ok && (bin_index_i >= low_bin_q) &&
                   ({1'b0, bin_index_i} < high_bin_q);
      bin_q     <= bin_index_i;
      ch_q      <= channel_index_i;
      x_re_q    <= sample_real_i;
      x_im_q    <= sample_imag_i;
    end
    case (state_q)
      ST_W6: begin
        res_re_q  <= '0;
        res_im_q  <= '0;
        res_sat_q <= 1'b0;
      end
      ST_Y: begin
        yr_q <= 26'((41'(sum_re_q) + 41'sd16384) >>> 15);
        yi_q <= 26'((41'(sum_im_q) + 41'sd16384) >>> 15);
      end
      ST_M4:  pr_q  <= 28'(rnd14);
      ST_M6:  pi_q  <= 28'(rnd14);
      ST_M8:  pd_q  <= 36'(rnd14);
      ST_M10: nr_q  <= nr_sat;
      ST_M12: ni_q  <= nr_sat;
      ST_M14: den_q <= den_sat;
      ST_M15: begin
        if (den_q == 32'd0) begin
          res_sat_q <= 1'b1;
        end
      end
      ST_M18: prod_re_q <= acc;
      ST_M20: prod_im_q <= acc;
      ST_DIV_RE: begin
        if (div_done) begin
          res_re_q  <= div_quot;
          res_sat_q <= res_sat_q | div_clip;
        end
      end
      ST_DIV_IM: begin
        if (div_done) begin
          res_im_q  <= div_quot;
          res_sat_q <= res_sat_q | div_clip;
        end
      end
      ST_EMIT: begin
        if (emit_go) begin
          out_bin_q <= bin_q;
          out_re_q  <= res_re_q;
          out_im_q  <= res_im_q;
          out_sat_q <= res_sat_q;
        end
      end
      default: begin
        den_q <= den_q;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_bin_o   = out_bin_q;
  assign out_real_o  = out_re_q;
  assign out_imag_o  = out_im_q;
  assign saturated_o = out_sat_q;

endmodule

[rtl/fbpb_ram.sv]
// ----------------------------------------------------------------------------
// fbpb_ram
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
module fbpb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port; the data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/fbpb_mac.sv]
// ----------------------------------------------------------------------------
// fbpb_mac
// Shared signed multiplier with a registered product and an accumulator.
// ----------------------------------------------------------------------------
module fbpb_mac
  import fbpb_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic signed [MulAW-1:0] a_i,
  input  logic signed [MulBW-1:0] b_i,
  input  mac_op_e                 op_i,
  output logic signed [AccW-1:0]  acc_o
);

  logic signed [MulAW+MulBW-1:0] prod;
  logic signed [AccW-1:0]        prod_q;
  logic signed [AccW-1:0]        acc_q;
  mac_op_e                       op_q;

  // Full-width product of the two operands.
  assign prod = a_i * b_i;

  // The product is registered before it reaches the accumulator.
  always_ff @(posedge clk_i) begin
    prod_q <= AccW'(prod);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q <= MAC_NOP;
    end else begin
      op_q <= op_i;
    end
  end

  // Accumulate the registered product under the registered operation.
  always_ff @(posedge clk_i) begin
    case (op_q)
      MAC_LOAD: acc_q <= prod_q;
      MAC_ADD:  acc_q <= acc_q + prod_q;
      MAC_SUB:  acc_q <= acc_q - prod_q;
      default:  acc_q <= acc_q;
    endcase
  end

  assign acc_o = acc_q;

endmodule

[rtl/fbpb_div.sv]
// ----------------------------------------------------------------------------
// fbpb_div
// Serial divider for the output scaling: rounded, saturated 16-bit quotient.
// ----------------------------------------------------------------------------
module fbpb_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [63:0] num_i,
  input  logic [31:0]        den_i,
  output logic               done_o,
  output logic [15:0]        quot_o,
  output logic               clip_o
);

  logic        neg;
  logic [63:0] mag;
  logic [63:0] nsum;
  logic [63:0] lim;
  logic        clip;

  logic        busy_q;
  logic        done_q;
  logic        neg_q;
  logic        clip_q;
  logic [3:0]  cnt_q;
  logic [47:0] rem_q;
  logic [47:0] dsr_q;
  logic [15:0] q_q;

  // Magnitude plus half the divisor, and the clipping bound.
  always_comb begin
    neg  = num_i[63];
    mag  = neg ? 64'(-num_i) : 64'(num_i);
    nsum = mag + {33'd0, den_i[31:1]};
    lim  = ({32'd0, den_i} << 15) + (neg ? {32'd0, den_i} : 64'd0);
    clip = (nsum >= lim);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        if (clip) begin
          done_q <= 1'b1;
        end else begin
          busy_q <= 1'b1;
          cnt_q  <= 4'd15;
        end
      end else if (busy_q) begin
        if (cnt_q == 4'd0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - 4'd1;
        end
      end
    end
  end

  // One quotient bit per cycle by restoring division.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q  <= neg;
      clip_q <= clip;
      rem_q  <= nsum[47:0];
      dsr_q  <= {1'b0, den_i, 15'd0};
      if (clip) begin
        q_q <= neg ? 16'h8000 : 16'h7fff;
      end else begin
        q_q <= '0;
      end
    end else if (busy_q) begin
      if (rem_q >= dsr_q) begin
        rem_q <= rem_q - dsr_q;
        q_q   <= {q_q[14:0], 1'b1};
      end else begin
        q_q <= {q_q[14:0], 1'b0};
      end
      dsr_q <= dsr_q >> 1;
    end
  end

  assign done_o = done_q;
  assign quot_o = neg_q ? 16'(-q_q) : q_q;
  assign clip_o = clip_q;

endmodule

[bench/tb_fixed_beamformer_projection_back.sv]
// ----------------------------------------------------------------------------
// tb_fixed_beamformer_projection_back
// Self-checking bench for the projection-back beamformer: weights and channel
// samples are driven through the input handshake, a scoreboard predicts each
// bin result and compares it field by field with what the block emits.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_fixed_beamformer_projection_back;
  import fbpb_pkg::*;

  localparam int CycleLimit = 2000000;

  typedef struct {
    logic               op;
    logic [7:0]         bin;
    logic [2:0]         ch;
    logic signed [15:0] xr;
    logic signed [15:0] xi;
    logic signed [15:0] wr;
    logic signed [15:0] wi;
    logic               last;
  } bf_item_t;

  typedef struct {
    logic [7:0]         bin;
    logic signed [15:0] re;
    logic signed [15:0] im;
    logic               sat;
  } bf_result_t;

  // Scoreboard: holds its own copy of the weights, the smoothed projection-back
  // state and the configuration, and the queue of bin results still due.
  class bin_scoreboard;
    longint    w_re[2048];
    longint    w_im[2048];
    longint    num_re[256];
    longint    num_im[256];
    longint    den[256];
    longint    acc_re, acc_im, ref_re, ref_im;
    longint    ff, ref_ch, low, high;
    bf_result_t due[$];
    int        fails;

    function new();
      for (int b = 0; b < 256; b++) begin
        num_re[b] = 65536;
        num_im[b] = 0;
        den[b]    = 65536;
      end
      acc_re = 0; acc_im = 0; ref_re = 0; ref_im = 0;
      ff = ForgetReset; ref_ch = RefReset; low = LowReset; high = HighReset;
      fails = 0;
    endfunction

    static function longint rnd(longint v, int k);
      return (v + (longint'(1) <<< (k - 1))) >>> k;
    endfunction

    static function longint wrap40(longint v);
      return (v <<< 24) >>> 24;
    endfunction

    static function longint sat32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    // Divide with rounding half away from zero, then clip to 16 bits.
    static function longint scale(longint prod, longint d, ref bit clip);
      longint mag, q;
      mag = (prod < 0) ? -prod : prod;
      q = (mag + d / 2) / d;
      if (prod < 0) begin
        if (q > 32768) begin
          clip = 1;
          return -32768;
        end
        return -q;
      end
      if (q > 32767) begin
        clip = 1;
        return 32767;
      end
      return q;
    endfunction

    function void write_reg(logic [1:0] idx, logic [31:0] v);
      case (idx)
        RegForget:  ff = v[15:0];
        RegRefChan: ref_ch = v[2:0];
        RegLowBin:  low = v[7:0];
        RegHighBin: high = v[8:0];
        default: ;
      endcase
    endfunction

    function void note(bf_item_t it);
      int         idx;
      longint     yr, yi, pr, pi, pd, gf, nr, ni, dacc, o_re, o_im;
      bit         clip;
      bf_result_t r;
      idx = it.bin * 8 + it.ch;
      if (it.op == OpWeight) begin
        w_re[idx] = it.wr;
        w_im[idx] = it.wi;
        return;
      end
      acc_re = wrap40(acc_re + w_re[idx] * it.xr + w_im[idx] * it.xi);
      acc_im = wrap40(acc_im + w_re[idx] * it.xi - w_im[idx] * it.xr);
      if (it.ch == ref_ch) begin
        ref_re = it.xr;
        ref_im = it.xi;
      end
      if (!it.last) return;
      o_re = 0; o_im = 0; clip = 0;
      if (it.bin >= low && it.bin < high) begin
        yr = rnd(acc_re, 15);
        yi = rnd(acc_im, 15);
        pr = rnd(yr * ref_re + yi * ref_im, 14);
        pi = rnd(yr * ref_im - yi * ref_re, 14);
        pd = rnd(yr * yr + yi * yi, 14);
        gf = 65536 - ff;
        nr = sat32(rnd(ff * num_re[it.bin] + gf * pr, 16));
        ni = sat32(rnd(ff * num_im[it.bin] + gf * pi, 16));
        dacc = rnd(ff * den[it.bin] + gf * pd, 16);
        if (dacc > 64'sd4294967295) dacc = 64'sd4294967295;
        num_re[it.bin] = nr;
        num_im[it.bin] = ni;
        den[it.bin]    = dacc;
        if (dacc == 0) begin
          clip = 1;
        end else begin
          o_re = scale(yr * nr - yi * ni, dacc, clip);
          o_im = scale(yr * ni + yi * nr, dacc, clip);
        end
      end
      acc_re = 0; acc_im = 0; ref_re = 0; ref_im = 0;
      r.bin = it.bin;
      r.re  = o_re[15:0];
      r.im  = o_im[15:0];
      r.sat = clip;
      due.push_back(r);
    endfunction

    function void check(bf_result_t got);
      bf_result_t exp_r;
      if (due.size() == 0) begin
        $error("result for bin %0d with none expected", got.bin);
        fails++;
        return;
      end
      exp_r = due.pop_front();
      if (got.bin !== exp_r.bin) begin
        $error("out_bin: expected %0d, got %0d", exp_r.bin, got.bin);
        fails++;
      end
      if (got.re !== exp_r.re) begin
        $error("out_real: expected %0d, got %0d", exp_r.re, got.re);
        fails++;
      end
      if (got.im !== exp_r.im) begin
        $error("out_imag: expected %0d, got %0d", exp_r.im, got.im);
        fails++;
      end
      if (got.sat !== exp_r.sat) begin
        $error("saturated: expected %0d, got %0d", exp_r.sat, got.sat);
        fails++;
      end
    endfunction
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [3:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic               operation_i = 1'b0;
  logic [7:0]         bin_index_i = '0;
  logic [2:0]         channel_index_i = '0;
  logic signed [15:0] sample_real_i = '0;
  logic signed [15:0] sample_imag_i = '0;
  logic signed [15:0] weight_real_i = '0;
  logic signed [15:0] weight_imag_i = '0;
  logic               last_channel_i = 1'b0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic [7:0]         out_bin_o;
  logic signed [15:0] out_real_o;
  logic signed [15:0] out_imag_o;
  logic               saturated_o;

  fixed_beamformer_projection_back dut (.*);

  bin_scoreboard sb = new();
  int  idle_pct  = 0;
  int  stall_pct = 0;
  int  sent      = 0;
  int  cycles    = 0;
  bit  loaded[256][8];

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Receiver side: random stalls, results checked at the accepting edge.
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= stall_pct);
    if (rst_ni && out_valid_o && out_ready_i) begin
      sb.check('{out_bin_o, out_real_o, out_imag_o, saturated_o});
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  function automatic logic [15:0] pick16();
    case ($urandom_range(7))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  // Drive one item and wait for it to be taken; caller sits at a clock edge.
  task automatic send(bf_item_t it);
    int gap;
    gap = 0;
    while ($urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    operation_i     <= it.op;
    bin_index_i     <= it.bin;
    channel_index_i <= it.ch;
    sample_real_i   <= it.xr;
    sample_imag_i   <= it.xi;
    weight_real_i   <= it.wr;
    weight_imag_i   <= it.wi;
    last_channel_i  <= it.last;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note(it);
    if (it.op == OpWeight) loaded[it.bin][it.ch] = 1'b1;
    sent++;
  endtask

  task automatic load_weight(logic [7:0] b, logic [2:0] c, logic signed [15:0] wr,
                             logic signed [15:0] wi, logic mark);
    send('{OpWeight, b, c, 16'($urandom), 16'($urandom), wr, wi, mark});
  endtask

  // A sample item; the weight it reads is loaded first if it never was.
  task automatic sample(logic [7:0] b, logic [2:0] c, logic signed [15:0] xr,
                        logic signed [15:0] xi, logic mark);
    if (!loaded[b][c]) load_weight(b, c, pick16(), pick16(), 1'($urandom_range(1)));
    send('{OpSample, b, c, xr, xi, 16'($urandom), 16'($urandom), mark});
  endtask

  // One bin of channel samples, the final one marked last.
  task automatic run_bin(logic [7:0] b, int nch);
    for (int c = 0; c < nch; c++) begin
      if ($urandom_range(9) == 0) begin
        load_weight(b, 3'(c), pick16(), pick16(), 1'($urandom_range(1)));
      end
      sample(b, 3'(c), pick16(), pick16(), c == nch - 1);
    end
  endtask

  // Let the block settle so that the configuration may change.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.due.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
  endtask

  task automatic apb_write(logic [1:0] idx, logic [31:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    sb.write_reg(idx, v);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic configure(int f, int rc, int lo, int hi);
    apb_write(RegForget, f);
    apb_write(RegRefChan, rc);
    apb_write(RegLowBin, lo);
    apb_write(RegHighBin, hi);
  endtask

  task automatic random_part(int count);
    int     target;
    logic [7:0] b;
    target = sent + count;
    while (sent < target) begin
      if ($urandom_range(99) < 80) begin
        // Mostly bins inside the processed band.
        if ($urandom_range(3) != 0 && sb.high > sb.low)
          b = 8'($urandom_range(int'(sb.low), int'((sb.high > 256 ? 256 : sb.high) - 1)));
        else
          b = 8'($urandom);
        run_bin(b, $urandom_range(1, 8));
      end else if ($urandom_range(1) == 0) begin
        load_weight(8'($urandom), 3'($urandom), pick16(), pick16(), 1'($urandom_range(1)));
      end else begin
        sample(8'($urandom), 3'($urandom), pick16(), pick16(), 1'($urandom_range(1)));
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Phase with reset configuration and no idling: directed cases first.
    idle_pct = 0; stall_pct = 0;
    for (int c = 0; c < 8; c++) load_weight(8'd1, 3'(c), 16'h7fff, 16'h8000, c == 7);
    load_weight(8'd127, 3'd0, 16'h8000, 16'h8000, 1'b0);
    for (int c = 0; c < 8; c++) sample(8'd1, 3'(c), 16'h7fff, 16'h8000, c == 7);
    sample(8'd127, 3'd0, 16'h8000, 16'h8000, 1'b1);
    sample(8'd0, 3'd0, 16'h1234, 16'h7fff, 1'b1);       // below the band
    sample(8'd128, 3'd1, 16'h8000, 16'h0001, 1'b1);     // above the band
    sample(8'd255, 3'd7, 16'h7fff, 16'h7fff, 1'b1);
    sample(8'd1, 3'd0, 16'h4000, 16'h0000, 1'b0);       // reference given twice
    sample(8'd1, 3'd0, 16'hc000, 16'h2000, 1'b0);
    sample(8'd127, 3'd0, 16'h0100, 16'h8000, 1'b1);     // mixed bins in one sum
    random_part(100);
    drain();

    // Zero forgetting factor, top reference channel, full band.
    configure(0, 7, 0, 256);
    idle_pct = 76; stall_pct = 0;
    for (int c = 0; c < 8; c++) sample(8'd5, 3'(c), 16'h0000, 16'h0000, c == 7);  // zero den
    random_part(100);
    drain();

    // Full forgetting factor, only the top bin processed.
    configure(65535, 3, 255, 256);
    idle_pct = 0; stall_pct = 76;
    run_bin(8'd255, 8);
    random_part(100);
    drain();

    // Empty band, then back to the reset settings with both sides idling.
    configure($urandom_range(65535), $urandom_range(7), 200, 100);
    idle_pct = 9; stall_pct = 9;
    random_part(30);
    drain();
    configure(ForgetReset, RefReset, LowReset, HighReset);
    idle_pct = 9; stall_pct = 9;
    random_part(80);

    in_valid_i <= 1'b0;
    while (sb.due.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (sb.fails == 0 && sb.due.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
